@@ rtl/core/itrt_pkg.sv @@
// Shared types, constants and the digit-to-ASCII mapping for integer_to_radix_text.
package itrt_pkg;

	localparam int RADIX_W   = 6;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 7;
	localparam int STEP_BITS = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [CHAR_W-1:0]  CH_ZERO        = 7'h30;
	localparam logic [CHAR_W-1:0]  CH_LOWER_A     = 7'h61;
	localparam logic [CHAR_W-1:0]  CH_MINUS       = 7'h2D;
	localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < DECIMAL_DIGITS) begin
			return CHAR_W'(CH_ZERO + dx);
		end
		return CHAR_W'(CH_LOWER_A + dx - {1'b0, DECIMAL_DIGITS});
	endfunction

endpackage

@@ rtl/core/itrt_front.sv @@
// Front end: radix register, request accept, sign and magnitude split.
module itrt_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic signed [VALUE_WIDTH-1:0]              value,
	input  logic                                       cfg_we,
	input  logic [itrt_pkg::RADIX_W-1:0]               cfg_wdata,
	input  itrt_pkg::q_stat_t                          q_stat,
	output logic                                       busy,
	output logic                                       push,
	output logic [VALUE_WIDTH+itrt_pkg::RADIX_W:0]     push_data
);

	logic [itrt_pkg::RADIX_W-1:0] radix_q;
	logic [itrt_pkg::RADIX_W-1:0] radix_clamped;
	logic [VALUE_WIDTH-1:0]       raw;
	logic [VALUE_WIDTH-1:0]       mag;
	logic                         neg;

	always_comb begin
		if (cfg_wdata < itrt_pkg::RADIX_MIN) begin
			radix_clamped = itrt_pkg::RADIX_MIN;
		end else if (cfg_wdata > itrt_pkg::RADIX_MAX) begin
			radix_clamped = itrt_pkg::RADIX_MAX;
		end else begin
			radix_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itrt_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= radix_clamped;
		end
	end

	// Unsigned magnitude, so the most negative value stays exact
	assign raw = value;
	assign neg = raw[VALUE_WIDTH-1];
	assign mag = neg ? VALUE_WIDTH'(~raw + 1'b1) : raw;

	assign busy      = q_stat.full;
	assign push      = start & ~q_stat.full;
	assign push_data = {radix_q, neg, mag};

endmodule

@@ rtl/core/itrt_queue.sv @@
// Two-entry request queue between the front end and the converter.
module itrt_queue #(
	parameter int WIDTH = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output itrt_pkg::q_stat_t q_stat
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

endmodule

@@ rtl/core/itrt_back.sv @@
// Back end: digit-serial radix division into a digit stack, then character output.
module itrt_back #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  itrt_pkg::q_stat_t                      q_stat,
	input  logic [VALUE_WIDTH+itrt_pkg::RADIX_W:0] pop_data,
	output logic                                   pop,
	output logic                                   strobe,
	output logic [itrt_pkg::CHAR_W-1:0]            character,
	output logic                                   last
);

	localparam int SB     = itrt_pkg::STEP_BITS;
	localparam int CHUNKS = (VALUE_WIDTH + SB - 1) / SB;
	localparam int PAD_W  = CHUNKS * SB;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int AW     = $clog2(MAX_DIGITS);
	localparam int RW     = itrt_pkg::RADIX_W;
	localparam int DW     = itrt_pkg::DIGIT_W;

	itrt_pkg::back_state_t state_q, state_d;

	logic [PAD_W-1:0] quo_q;
	logic [DW-1:0]    rem_q;
	logic [RW-1:0]    radix_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CW-1:0]    chunk_q;

	logic             out_v_s1;
	logic             sign_s1;
	logic             last_s1;
	logic [DW-1:0]    rd_s1;

	logic [DW-1:0]    stack_mem [MAX_DIGITS];

	logic [PAD_W-1:0] quo_next;
	logic [DW-1:0]    rem_next;
	logic [SB-1:0]    qbits;
	logic [CNT_W-1:0] cnt_inc;
	logic             chunk_end;
	logic             div_step;
	logic             emit_sign;
	logic             emit_read;

	// Long division of one byte of the quotient against the radix
	always_comb begin
		logic [DW-1:0] r;
		logic [DW:0]   t;
		logic [SB-1:0] top;
		r     = rem_q;
		top   = quo_q[PAD_W-1 -: SB];
		qbits = '0;
		for (int i = SB - 1; i >= 0; i--) begin
			t = {r, top[i]};
			if (t >= {1'b0, radix_q}) begin
				t        = t - {1'b0, radix_q};
				qbits[i] = 1'b1;
			end
			r = t[DW-1:0];
		end
		rem_next = r;
		quo_next = (quo_q << SB) | PAD_W'(qbits);
	end

	assign cnt_inc   = cnt_q + 1'b1;
	assign chunk_end = (chunk_q == '0);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_step  = 1'b0;
		emit_sign = 1'b0;
		emit_read = 1'b0;
		case (state_q)
			itrt_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = itrt_pkg::BK_DIV;
				end
			end
			itrt_pkg::BK_DIV: begin
				div_step = 1'b1;
				if (chunk_end && (quo_next == '0 || cnt_inc == CNT_W'(MAX_DIGITS))) begin
					state_d = itrt_pkg::BK_EMIT;
				end
			end
			itrt_pkg::BK_EMIT: begin
				if (neg_q) begin
					emit_sign = 1'b1;
				end else begin
					emit_read = 1'b1;
					if (ptr_q == CNT_W'(1)) begin
						state_d = itrt_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = itrt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itrt_pkg::BK_IDLE;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			chunk_q  <= '0;
			out_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			out_v_s1 <= emit_sign | emit_read;
			if (pop) begin
				neg_q   <= pop_data[VALUE_WIDTH];
				cnt_q   <= '0;
				chunk_q <= CW'(CHUNKS - 1);
			end
			if (div_step) begin
				if (chunk_end) begin
					chunk_q <= CW'(CHUNKS - 1);
					cnt_q   <= cnt_inc;
					ptr_q   <= cnt_inc;
				end else begin
					chunk_q <= chunk_q - 1'b1;
				end
			end
			if (emit_sign) begin
				neg_q <= 1'b0;
			end
			if (emit_read) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q   <= PAD_W'(pop_data[VALUE_WIDTH-1:0]);
			rem_q   <= '0;
			radix_q <= pop_data[VALUE_WIDTH+RW:VALUE_WIDTH+1];
		end
		if (div_step) begin
			quo_q <= quo_next;
			rem_q <= chunk_end ? '0 : rem_next;
		end
		sign_s1 <= emit_sign;
		last_s1 <= emit_read && (ptr_q == CNT_W'(1));
	end

	// Digit stack: push at digit end, pop most significant first
	always_ff @(posedge clk) begin
		if (div_step && chunk_end) begin
			stack_mem[cnt_q[AW-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_read) begin
			rd_s1 <= stack_mem[AW'(ptr_q - 1'b1)];
		end
	end

	assign strobe    = out_v_s1;
	assign character = sign_s1 ? itrt_pkg::CH_MINUS : itrt_pkg::digit_char(rd_s1);
	assign last      = last_s1;

endmodule

@@ rtl/core/integer_to_radix_text.sv @@
// Top level of the integer to radix text converter.
// Converts a signed integer to ASCII text in the radix held in the radix register (2 to 36,
// writes clamped), one character per strobe, most significant first, a leading '-' for
// negative values, the final character marked by last. Requests are taken while busy is
// low; a two-entry queue lets up to two requests wait behind the one being converted. The
// converter divides by the radix eight quotient bits per cycle, a full pass over the quotient
// for each digit, then characters stream one per cycle. Results are never held: each stays
// exactly one cycle.
module integer_to_radix_text #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [VALUE_WIDTH-1:0]     value,
	input  logic                              cfg_we,
	input  logic [itrt_pkg::RADIX_W-1:0]      cfg_wdata,
	output logic                              strobe,
	output logic [itrt_pkg::CHAR_W-1:0]       character,
	output logic                              last
);

	localparam int QW = VALUE_WIDTH + itrt_pkg::RADIX_W + 1;

	itrt_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;
	logic [QW-1:0]     push_data;
	logic [QW-1:0]     pop_data;

	itrt_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	itrt_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	itrt_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule

@@ bench/tb_top.sv @@
// Testbench for integer_to_radix_text: directed table, then random values over several radixes.
module tb_top;

	localparam int CHAR_W  = itrt_pkg::CHAR_W;
	localparam int RADIX_W = itrt_pkg::RADIX_W;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	typedef enum logic {
		ROW_RADIX,
		ROW_VALUE
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [RADIX_W-1:0] wdata;
		logic signed [31:0] val;
		string              text;
	} dir_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	logic signed [31:0]  value     = '0;
	logic                cfg_we    = 1'b0;
	logic [RADIX_W-1:0]  cfg_wdata = '0;
	logic                strobe;
	logic [CHAR_W-1:0]   character;
	logic                last;

	text_char_t  pending_chars[$];
	text_char_t  head;
	dir_row_t    directed_rows[$];
	int unsigned radix_now = itrt_pkg::RADIX_RESET;
	int          errors    = 0;

	integer_to_radix_text u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always #1 clk = ~clk;

	function automatic logic [CHAR_W-1:0] ascii_of_digit(int unsigned d);
		if (d < itrt_pkg::DECIMAL_DIGITS) begin
			return itrt_pkg::CH_ZERO + CHAR_W'(d);
		end
		return itrt_pkg::CH_LOWER_A + CHAR_W'(d - itrt_pkg::DECIMAL_DIGITS);
	endfunction

	// Queue the characters of v in the current radix, sign first.
	function automatic void predict_text(logic signed [31:0] v);
		logic [31:0] mag;
		int unsigned digits[$];
		mag = v[31] ? (~v + 32'd1) : v;
		do begin
			digits.push_back(mag % radix_now);
			mag = mag / radix_now;
		end while (mag != 0);
		if (v[31]) begin
			pending_chars.push_back('{ch: itrt_pkg::CH_MINUS, last: 1'b0});
		end
		for (int i = digits.size() - 1; i >= 0; i--) begin
			pending_chars.push_back('{ch: ascii_of_digit(digits[i]), last: (i == 0)});
		end
	endfunction

	function automatic void expect_literal(string s);
		for (int i = 0; i < s.len(); i++) begin
			pending_chars.push_back('{ch: CHAR_W'(s[i]), last: (i == s.len() - 1)});
		end
	endfunction

	function automatic logic signed [31:0] random_value();
		logic signed [31:0] v;
		longint             p;
		int                 k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				v = $urandom_range(0, radix_now * radix_now * radix_now);
				if ($urandom_range(0, 1)) v = -v;
			end
			6: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh0000_0000;
					1: v = -32'sd1;
					2: v = 32'sh8000_0000;
					3: v = 32'sh7fff_ffff;
					default: v = 32'sd1;
				endcase
			end
			default: begin
				// radix powers and their neighbors change the digit count
				p = 1;
				k = $urandom_range(1, 31);
				repeat (k) begin
					if (p * radix_now <= 64'sh7fff_ffff) p = p * radix_now;
				end
				v = 32'(p + $urandom_range(0, 2) - 1);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// Drop start and hold until every character of the queued requests has come out.
	task automatic drain_text();
		@(negedge clk);
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(logic [RADIX_W-1:0] w);
		drain_text();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (w < itrt_pkg::RADIX_MIN) radix_now = itrt_pkg::RADIX_MIN;
		else if (w > itrt_pkg::RADIX_MAX) radix_now = itrt_pkg::RADIX_MAX;
		else radix_now = w;
	endtask

	task automatic send_value(logic signed [31:0] v, int gap, string literal);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (literal.len() != 0) expect_literal(literal);
		else predict_text(v);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character: actual %h last %b", character, last);
				errors++;
			end else begin
				head = pending_chars.pop_front();
				if (character !== head.ch) begin
					$error("character: expected %h, actual %h", head.ch, character);
					errors++;
				end
				if (last !== head.last) begin
					$error("last: expected %b, actual %b", head.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		bit no_gaps;
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd0, "0"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd7, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, -32'sd1, "-1"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh7fff_ffff, "2147483647"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh8000_0000, "-2147483648"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd1234567890, ""});
		// writes below the range clamp to 2
		directed_rows.push_back('{ROW_RADIX, 6'd0, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd5, "101"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh8000_0000, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh7fff_ffff, ""});
		directed_rows.push_back('{ROW_RADIX, 6'd1, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd2, "10"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, -32'sd1, "-1"});
		// writes above the range clamp to 36
		directed_rows.push_back('{ROW_RADIX, 6'd63, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd35, "z"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd36, "10"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh8000_0000, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sh7fff_ffff, ""});
		directed_rows.push_back('{ROW_RADIX, 6'd37, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, -32'sd35, "-z"});
		directed_rows.push_back('{ROW_RADIX, 6'd16, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'shdead_beef, "-21524111"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd255, "ff"});
		directed_rows.push_back('{ROW_RADIX, 6'd8, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd8, "10"});
		directed_rows.push_back('{ROW_VALUE, 6'd0, -32'sd9, "-11"});
		directed_rows.push_back('{ROW_RADIX, 6'd35, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd34, "y"});
		directed_rows.push_back('{ROW_RADIX, 6'd10, 32'sd0, ""});
		directed_rows.push_back('{ROW_VALUE, 6'd0, 32'sd10, "10"});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_RADIX) begin
				write_radix(directed_rows[i].wdata);
			end else begin
				send_value(directed_rows[i].val, $urandom_range(0, 3), directed_rows[i].text);
			end
		end

		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 0) write_radix(6'd0);
			else if (phase == 1) write_radix(6'd63);
			else write_radix(RADIX_W'($urandom_range(0, 63)));
			no_gaps = (phase % 3 == 0);
			for (int n = 0; n < 50; n++) begin
				// let the queue run empty now and then
				if ($urandom_range(0, 29) == 0) drain_text();
				send_value(random_value(), no_gaps ? 0 : $urandom_range(0, 11), "");
			end
		end

		drain_text();
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/itrt_pkg.sv
rtl/core/itrt_front.sv
rtl/core/itrt_queue.sv
rtl/core/itrt_back.sv
rtl/core/integer_to_radix_text.sv
bench/tb_top.sv
